// File: rtl/fcgi_pkg.sv
// ----------------------------------------------------------------------------
// fcgi_pkg
// Shared types and codes for the FastCGI record deframer.
// ----------------------------------------------------------------------------
package fcgi_pkg;

  // result kinds
  localparam logic [2:0] KIND_PAIR  = 3'd0;
  localparam logic [2:0] KIND_KEY   = 3'd1;
  localparam logic [2:0] KIND_VALUE = 3'd2;
  localparam logic [2:0] KIND_BODY  = 3'd3;
  localparam logic [2:0] KIND_PDONE = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  // record types of interest
  localparam logic [7:0] TYPE_PARAMS = 8'd4;
  localparam logic [7:0] TYPE_STDIN  = 8'd5;

  // largest single-byte length
  localparam logic [7:0] SHORT_LEN_MAX = 8'd127;

  localparam int HDR_BYTES = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_PAD    = 2'd2
  } rec_phase_t;

  typedef enum logic [2:0] {
    PP_KEY_FIRST = 3'd0,
    PP_KEY_MORE  = 3'd1,
    PP_VAL_FIRST = 3'd2,
    PP_VAL_MORE  = 3'd3,
    PP_KEY_DATA  = 3'd4,
    PP_VAL_DATA  = 3'd5
  } pair_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] key_length;
    logic [15:0] value_length;
    logic [15:0] request_id;
    logic        last;
  } res_t;

endpackage

// File: rtl/fcgi_in_if.sv
// ----------------------------------------------------------------------------
// fcgi_in_if
// Byte stream channel: valid/ready handshake with one stream byte.
// ----------------------------------------------------------------------------
interface fcgi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: rtl/fcgi_out_if.sv
// ----------------------------------------------------------------------------
// fcgi_out_if
// Result channel: valid/ready handshake with one parsed result.
// ----------------------------------------------------------------------------
interface fcgi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [15:0] key_length;
  logic [15:0] value_length;
  logic [15:0] request_id;
  logic        last;

  modport source (output valid, output kind, output data, output key_length,
                  output value_length, output request_id, output last,
                  input ready);
  modport sink   (input valid, input kind, input data, input key_length,
                  input value_length, input request_id, input last,
                  output ready);
endinterface

// File: rtl/fcgi_parser.sv
// ----------------------------------------------------------------------------
// fcgi_parser
// Record and name-value pair state; one stream byte per accepted transfer.
// ----------------------------------------------------------------------------
module fcgi_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  output logic           res_valid,
  output fcgi_pkg::res_t res
);
  import fcgi_pkg::*;

  rec_phase_t  record_phase, record_phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [15:0] current_request, current_request_next;
  logic [15:0] content_left, content_left_next;
  logic [7:0]  padding_left, padding_left_next;
  pair_phase_t pair_phase, pair_phase_next;
  logic [1:0]  length_bytes_left, length_bytes_left_next;
  logic [15:0] accum_low, accum_low_next;     // low 16 bits of the long length
  logic        accum_high, accum_high_next;   // upper bits nonzero
  logic [15:0] key_left, key_left_next;
  logic [15:0] value_left, value_left_next;
  logic        stdin_seen, stdin_seen_next;
  logic        stream_ended, stream_ended_next;
  logic        error_flag, error_flag_next;

  logic [15:0] rem;
  logic [1:0]  lb_n;
  logic        long_done;
  logic [15:0] new_val;
  logic        err_now;

  always_comb begin
    record_phase_next      = record_phase;
    header_count_next      = header_count;
    record_kind_next       = record_kind;
    current_request_next   = current_request;
    content_left_next      = content_left;
    padding_left_next      = padding_left;
    pair_phase_next        = pair_phase;
    length_bytes_left_next = length_bytes_left;
    accum_low_next         = accum_low;
    accum_high_next        = accum_high;
    key_left_next          = key_left;
    value_left_next        = value_left;
    stdin_seen_next        = stdin_seen;
    stream_ended_next      = stream_ended;
    error_flag_next        = error_flag;
    res_valid              = 1'b0;
    res.kind               = KIND_PAIR;
    res.data               = 8'd0;
    res.key_length         = 16'd0;
    res.value_length       = 16'd0;
    res.last               = 1'b0;
    rem                    = content_left - {15'd0, (content_left != 16'd0)};
    lb_n                   = (length_bytes_left == 2'd0) ? 2'd1 : length_bytes_left;
    long_done              = 1'b0;
    new_val                = 16'd0;
    err_now                = 1'b0;

    if (accept && !error_flag && !stream_ended) begin
      if (record_phase == PH_HEADER) begin
        case (header_count)
          3'd1: record_kind_next = in_byte;
          3'd2: current_request_next = {in_byte, current_request[7:0]};
          3'd3: current_request_next = {current_request[15:8], in_byte};
          3'd4: content_left_next = {in_byte, 8'h00};
          3'd5: content_left_next = {content_left[15:8], in_byte};
          3'd6: padding_left_next = in_byte;
          default: ;
        endcase
        if (header_count != 3'(HDR_BYTES - 1)) begin
          header_count_next = header_count + 3'd1;
        end else begin
          header_count_next = 3'd0;
          pair_phase_next   = PP_KEY_FIRST;
          if (record_kind == TYPE_STDIN) begin
            stdin_seen_next = 1'b1;
            if (content_left == 16'd0) begin
              stream_ended_next = 1'b1;
              res_valid         = 1'b1;
              res.kind          = KIND_END;
            end else begin
              record_phase_next = PH_BODY;
              if (!stdin_seen) begin
                res_valid = 1'b1;
                res.kind  = KIND_PDONE;
              end
            end
          end else if (content_left == 16'd0) begin
            record_phase_next = (padding_left != 8'd0) ? PH_PAD : PH_HEADER;
          end else begin
            record_phase_next = PH_BODY;
          end
        end
      end else if (record_phase == PH_BODY) begin
        content_left_next = rem;
        if (record_kind == TYPE_STDIN) begin
          res_valid = 1'b1;
          res.kind  = KIND_BODY;
          res.data  = in_byte;
          res.last  = (rem == 16'd0);
        end else if (record_kind == TYPE_PARAMS && !stdin_seen) begin
          unique case (pair_phase)
            PP_KEY_FIRST, PP_VAL_FIRST: begin
              if (in_byte > SHORT_LEN_MAX) begin
                accum_high_next        = (in_byte[6:0] != 7'd0);
                accum_low_next         = 16'd0;
                length_bytes_left_next = 2'd3;
                pair_phase_next = (pair_phase == PP_KEY_FIRST) ? PP_KEY_MORE : PP_VAL_MORE;
                err_now = (rem == 16'd0);
              end else if (pair_phase == PP_KEY_FIRST) begin
                key_left_next   = {8'd0, in_byte};
                pair_phase_next = PP_VAL_FIRST;
                err_now = (rem == 16'd0);
              end else begin
                long_done = 1'b1;
                new_val   = {8'd0, in_byte};
              end
            end
            PP_KEY_MORE, PP_VAL_MORE: begin
              case (lb_n)
                2'd3:    accum_high_next = accum_high | (in_byte != 8'd0);
                2'd2:    accum_low_next  = {in_byte, accum_low[7:0]};
                default: accum_low_next  = {accum_low[15:8], in_byte};
              endcase
              length_bytes_left_next = lb_n - 2'd1;
              if (lb_n == 2'd1) begin
                if (accum_high) begin
                  err_now = 1'b1;
                end else if (pair_phase == PP_KEY_MORE) begin
                  key_left_next   = accum_low_next;
                  pair_phase_next = PP_VAL_FIRST;
                  err_now = (rem == 16'd0);
                end else begin
                  long_done = 1'b1;
                  new_val   = accum_low_next;
                end
              end else begin
                err_now = (rem == 16'd0);
              end
            end
            PP_KEY_DATA: begin
              key_left_next = key_left - 16'd1;
              if (key_left_next == 16'd0) begin
                pair_phase_next = (value_left != 16'd0) ? PP_VAL_DATA : PP_KEY_FIRST;
              end
              res_valid = 1'b1;
              res.kind  = KIND_KEY;
              res.data  = in_byte;
              res.last  = (key_left_next == 16'd0);
            end
            PP_VAL_DATA: begin
              value_left_next = value_left - 16'd1;
              if (value_left_next == 16'd0) begin
                pair_phase_next = PP_KEY_FIRST;
              end
              res_valid = 1'b1;
              res.kind  = KIND_VALUE;
              res.data  = in_byte;
              res.last  = (value_left_next == 16'd0);
            end
            default: err_now = 1'b1;
          endcase
          // value length complete: check the pair fits in the record
          if (long_done) begin
            value_left_next = new_val;
            if ({1'b0, key_left} + {1'b0, new_val} > {1'b0, rem}) begin
              err_now = 1'b1;
            end else begin
              pair_phase_next = (key_left != 16'd0) ? PP_KEY_DATA :
                                ((new_val != 16'd0) ? PP_VAL_DATA : PP_KEY_FIRST);
              res_valid        = 1'b1;
              res.kind         = KIND_PAIR;
              res.key_length   = key_left;
              res.value_length = new_val;
            end
          end
          if (err_now) begin
            error_flag_next = 1'b1;
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
          end
        end
        if (rem == 16'd0 && !error_flag_next) begin
          record_phase_next = (padding_left != 8'd0) ? PH_PAD : PH_HEADER;
        end
      end else begin
        padding_left_next = padding_left - {7'd0, (padding_left != 8'd0)};
        if (padding_left_next == 8'd0) begin
          record_phase_next = PH_HEADER;
        end
      end
    end
    res.request_id = current_request_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_phase      <= PH_HEADER;
      header_count      <= 3'd0;
      record_kind       <= 8'd0;
      current_request   <= 16'd0;
      content_left      <= 16'd0;
      padding_left      <= 8'd0;
      pair_phase        <= PP_KEY_FIRST;
      length_bytes_left <= 2'd0;
      accum_low         <= 16'd0;
      accum_high        <= 1'b0;
      key_left          <= 16'd0;
      value_left        <= 16'd0;
      stdin_seen        <= 1'b0;
      stream_ended      <= 1'b0;
      error_flag        <= 1'b0;
    end else begin
      record_phase      <= record_phase_next;
      header_count      <= header_count_next;
      record_kind       <= record_kind_next;
      current_request   <= current_request_next;
      content_left      <= content_left_next;
      padding_left      <= padding_left_next;
      pair_phase        <= pair_phase_next;
      length_bytes_left <= length_bytes_left_next;
      accum_low         <= accum_low_next;
      accum_high        <= accum_high_next;
      key_left          <= key_left_next;
      value_left        <= value_left_next;
      stdin_seen        <= stdin_seen_next;
      stream_ended      <= stream_ended_next;
      error_flag        <= error_flag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_quiet_after_stop: assert property (@(posedge clk) disable iff (rst)
    (error_flag || stream_ended) |-> !res_valid)
    else $error("result produced after error or end of stream");
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_ERROR) |=> error_flag)
    else $error("error result did not set the sticky flag");
  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_END) |=> stream_ended)
    else $error("end result did not stop the stream");
  a_hdr_count_phase: assert property (@(posedge clk) disable iff (rst)
    (header_count != 3'd0) |-> (record_phase == PH_HEADER))
    else $error("header count advanced outside the header");
`endif

endmodule

// File: rtl/fcgi_out_reg.sv
// ----------------------------------------------------------------------------
// fcgi_out_reg
// Result register; refills in the same cycle the held result is taken.
// ----------------------------------------------------------------------------
module fcgi_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  fcgi_pkg::res_t res,
  output logic           can_take,
  fcgi_out_if.source     dst
);
  import fcgi_pkg::*;

  logic valid;
  res_t held;

  assign can_take = !valid || dst.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (dst.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign dst.valid        = valid;
  assign dst.kind         = held.kind;
  assign dst.data         = held.data;
  assign dst.key_length   = held.key_length;
  assign dst.value_length = held.value_length;
  assign dst.request_id   = held.request_id;
  assign dst.last         = held.last;

`ifndef NO_ASSERTIONS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (valid && held.kind == $past(res.kind) && held.data == $past(res.data)))
    else $error("loaded result not presented");
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (valid && dst.ready && !load) |=> !valid)
    else $error("taken result presented twice");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (valid && !dst.ready) |-> !load)
    else $error("held result overwritten while stalled");
`endif

endmodule

// File: rtl/fastcgi_record_deframer.sv
// ----------------------------------------------------------------------------
// fastcgi_record_deframer
// FastCGI byte stream deframer: record headers, PARAMS pairs, STDIN body.
// ----------------------------------------------------------------------------
// Usage:
//   stream : one FastCGI stream byte per transfer (in_byte).
//   result : zero or one result per accepted byte: pair headers with decoded
//            key/value lengths, key and value bytes, STDIN body bytes, params
//            done, end of stream, or a sticky error. request_id follows the
//            most recent record header.
// Result timing: a byte's result is registered and appears on the result channel
//   in the cycle after the byte's transfer.
// Throughput: one byte per cycle while not stalled; each byte is one update of the parser
//   state, and the single result register refills in the cycle it drains.
// Stall: while the result register holds an untaken result, stream.ready
//   is low; header, padding and skipped bytes are also held off then.
// Reset (rst, synchronous): parser returns to the first header byte, all
//   counters and flags clear and the result register empties.
// After an error or end of stream, bytes are still accepted but give no
//   result until reset.
// ----------------------------------------------------------------------------
module fastcgi_record_deframer (
  input  logic       clk,
  input  logic       rst,
  fcgi_in_if.sink    stream,
  fcgi_out_if.source result
);
  import fcgi_pkg::*;

  logic accept;
  logic res_valid;
  logic can_take;
  res_t res;

  assign stream.ready = can_take;
  assign accept       = stream.valid && can_take;

  fcgi_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (stream.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fcgi_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_take (can_take),
    .dst      (result)
  );

endmodule

// File: tb/fastcgi_record_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fastcgi_record_deframer_tb
// Drives FastCGI byte streams into the deframer and checks every result
// against a cycle-free parser kept in step with each accepted byte. A short
// table of hand-checked bytes comes first, then random PARAMS, STDIN and
// foreign records, then one stream ending (end of stream or one of the
// length errors) followed by bytes that must be ignored.
// ----------------------------------------------------------------------------
module fastcgi_record_deframer_tb;
  import fcgi_pkg::*;

  localparam int ITEMS        = 1500;
  localparam int STDIN_START  = 700;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_ROWS     = 27;
  localparam int TAIL_MAX     = 64;

  localparam logic [15:0] DIR_ID        = 16'hFFFF;
  localparam logic [31:0] LEN_LIMIT     = 32'h0000_FFFF;
  localparam logic [7:0]  LONG_LEN_FLAG = 8'h80;

  typedef enum int {
    END_OF_STREAM,
    KEY_LEN_CUT,
    VALUE_LEN_MISSING,
    VALUE_LEN_CUT,
    PAIR_OVERRUN,
    KEY_LEN_HUGE,
    VALUE_LEN_HUGE
  } stream_close_t;

  typedef struct packed {
    logic [7:0] b;
    logic       has_res;
    res_t       res;
  } dir_row_t;

  typedef logic [7:0] byte_q_t [$];

  logic clk = 1'b0;
  logic rst;

  fcgi_in_if  stream ();
  fcgi_out_if result ();

  fastcgi_record_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result)
  );

  always #5 clk = ~clk;

  res_t     pending_results [$];
  dir_row_t dir_tab [DIR_ROWS];
  int       errors = 0;
  int       cycles = 0;
  int       bytes_sent = 0;
  bit       calm = 1'b0;

  // parser state mirrored from the block
  rec_phase_t  frame_phase;
  logic [2:0]  hdr_pos;
  logic [7:0]  rec_type;
  logic [15:0] cur_id;
  logic [15:0] body_left;
  logic [7:0]  pad_left;
  pair_phase_t kv_phase;
  logic [1:0]  len_left;
  logic [31:0] len_acc;
  logic [15:0] key_rem;
  logic [15:0] val_rem;
  bit          stdin_started;
  bit          stream_done;
  bit          sticky_err;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // alternate between stretches with random idling and stretches without
  initial begin
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // parser prediction
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    frame_phase   = PH_HEADER;
    hdr_pos       = '0;
    rec_type      = '0;
    cur_id        = '0;
    body_left     = '0;
    pad_left      = '0;
    kv_phase      = PP_KEY_FIRST;
    len_left      = '0;
    len_acc       = '0;
    key_rem       = '0;
    val_rem       = '0;
    stdin_started = 1'b0;
    stream_done   = 1'b0;
    sticky_err    = 1'b0;
  endfunction

  function automatic res_t make_res(logic [2:0] kind, logic [7:0] data,
                                    logic [15:0] kl, logic [15:0] vl, logic last);
    res_t r;
    r.kind         = kind;
    r.data         = data;
    r.key_length   = kl;
    r.value_length = vl;
    r.request_id   = cur_id;
    r.last         = last;
    return r;
  endfunction

  function automatic res_t flag_error();
    sticky_err = 1'b1;
    return make_res(KIND_ERROR, 8'h00, 16'h0, 16'h0, 1'b0);
  endfunction

  // both lengths known: they must fit in what is left of the record
  function automatic res_t close_lengths(logic [15:0] rem);
    if ({1'b0, key_rem} + {1'b0, val_rem} > {1'b0, rem}) begin
      return flag_error();
    end
    if (key_rem != 0) begin
      kv_phase = PP_KEY_DATA;
    end else if (val_rem != 0) begin
      kv_phase = PP_VAL_DATA;
    end else begin
      kv_phase = PP_KEY_FIRST;
    end
    return make_res(KIND_PAIR, 8'h00, key_rem, val_rem, 1'b0);
  endfunction

  function automatic void open_long(logic [7:0] b, pair_phase_t nxt);
    len_acc  = {b ^ LONG_LEN_FLAG, 24'h0};
    len_left = 2'd3;
    kv_phase = nxt;
  endfunction

  function automatic bit long_complete(logic [7:0] b);
    int n;
    n = (len_left == 0) ? 1 : int'(len_left);
    len_acc  = len_acc | (32'(b) << (8 * (n - 1)));
    len_left = 2'(n - 1);
    return len_left == 0;
  endfunction

  function automatic bit decode_pair_byte(logic [7:0] b, logic [15:0] rem,
                                          output res_t r);
    bit cut;
    cut = 1'b0;
    r   = '0;
    case (kv_phase)
      PP_KEY_FIRST: begin
        if (b > SHORT_LEN_MAX) begin
          open_long(b, PP_KEY_MORE);
        end else begin
          key_rem  = 16'(b);
          kv_phase = PP_VAL_FIRST;
        end
        cut = (rem == 0);
      end
      PP_KEY_MORE: begin
        if (long_complete(b)) begin
          if (len_acc > LEN_LIMIT) begin
            r = flag_error();
            return 1'b1;
          end
          key_rem  = len_acc[15:0];
          kv_phase = PP_VAL_FIRST;
        end
        cut = (rem == 0);
      end
      PP_VAL_FIRST: begin
        if (b <= SHORT_LEN_MAX) begin
          val_rem = 16'(b);
          r = close_lengths(rem);
          return 1'b1;
        end
        open_long(b, PP_VAL_MORE);
        cut = (rem == 0);
      end
      PP_VAL_MORE: begin
        if (long_complete(b)) begin
          if (len_acc > LEN_LIMIT) begin
            r = flag_error();
          end else begin
            val_rem = len_acc[15:0];
            r = close_lengths(rem);
          end
          return 1'b1;
        end
        cut = (rem == 0);
      end
      PP_KEY_DATA: begin
        key_rem = key_rem - 16'd1;
        if (key_rem == 0) begin
          kv_phase = (val_rem != 0) ? PP_VAL_DATA : PP_KEY_FIRST;
        end
        r = make_res(KIND_KEY, b, 16'h0, 16'h0, key_rem == 0);
        return 1'b1;
      end
      PP_VAL_DATA: begin
        val_rem = val_rem - 16'd1;
        if (val_rem == 0) begin
          kv_phase = PP_KEY_FIRST;
        end
        r = make_res(KIND_VALUE, b, 16'h0, 16'h0, val_rem == 0);
        return 1'b1;
      end
      default: begin
        r = flag_error();
        return 1'b1;
      end
    endcase
    if (cut) begin
      r = flag_error();
    end
    return cut;
  endfunction

  function automatic bit parse_byte(logic [7:0] b, output res_t r);
    bit got;
    bit first;
    got = 1'b0;
    r   = '0;
    if (sticky_err || stream_done) begin
      return 1'b0;
    end
    case (frame_phase)
      PH_HEADER: begin
        case (hdr_pos)
          3'd1: rec_type = b;
          3'd2: cur_id[15:8] = b;
          3'd3: cur_id[7:0] = b;
          3'd4: body_left = {b, 8'h00};
          3'd5: body_left[7:0] = b;
          3'd6: pad_left = b;
          default: ;
        endcase
        if (hdr_pos != 3'd7) begin
          hdr_pos = hdr_pos + 3'd1;
          return 1'b0;
        end
        hdr_pos  = '0;
        kv_phase = PP_KEY_FIRST;
        if (rec_type == TYPE_STDIN) begin
          first = !stdin_started;
          stdin_started = 1'b1;
          if (body_left == 0) begin
            stream_done = 1'b1;
            r = make_res(KIND_END, 8'h00, 16'h0, 16'h0, 1'b0);
            return 1'b1;
          end
          frame_phase = PH_BODY;
          if (first) begin
            r = make_res(KIND_PDONE, 8'h00, 16'h0, 16'h0, 1'b0);
          end
          return first;
        end
        if (body_left != 0) begin
          frame_phase = PH_BODY;
        end else begin
          frame_phase = (pad_left != 0) ? PH_PAD : PH_HEADER;
        end
      end
      PH_BODY: begin
        if (body_left != 0) begin
          body_left = body_left - 16'd1;
        end
        if (rec_type == TYPE_STDIN) begin
          r = make_res(KIND_BODY, b, 16'h0, 16'h0, body_left == 0);
          got = 1'b1;
        end else if (rec_type == TYPE_PARAMS && !stdin_started) begin
          got = decode_pair_byte(b, body_left, r);
        end
        if (body_left == 0 && !sticky_err) begin
          frame_phase = (pad_left != 0) ? PH_PAD : PH_HEADER;
        end
      end
      default: begin
        if (pad_left != 0) begin
          pad_left = pad_left - 8'd1;
        end
        if (pad_left == 0) begin
          frame_phase = PH_HEADER;
        end
      end
    endcase
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // stream side
  // --------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b, logic has_res, res_t hand_res);
    int   gap;
    res_t r;
    bit   got;
    gap = draw_wait();
    if (gap > 0) begin
      stream.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream.valid   <= 1'b1;
    stream.in_byte <= b;
    @(posedge clk);
    while (!stream.ready) @(posedge clk);
    got = parse_byte(b, r);
    if (has_res) begin
      pending_results.push_back(hand_res);
    end else if (got) begin
      pending_results.push_back(r);
    end
    bytes_sent++;
  endtask

  task automatic feed(logic [7:0] b);
    push_byte(b, 1'b0, '0);
  endtask

  task automatic send_record(logic [7:0] rtype, logic [15:0] id, input byte_q_t body,
                             int pad);
    logic [15:0] len;
    len = 16'(body.size());
    feed(rnd_byte());                   // version
    feed(rtype);
    feed(id[15:8]);
    feed(id[7:0]);
    feed(len[15:8]);
    feed(len[7:0]);
    feed(8'(pad));
    feed(rnd_byte());                   // reserved
    foreach (body[i]) feed(body[i]);
    repeat (pad) feed(rnd_byte());
  endtask

  task automatic put_length(ref byte_q_t q, input int len, input bit wide);
    if (wide || len > int'(SHORT_LEN_MAX)) begin
      q.push_back(LONG_LEN_FLAG);
      q.push_back(8'h00);
      q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end else begin
      q.push_back(8'(len));
    end
  endtask

  function automatic int draw_len();
    case ($urandom_range(0, 9))
      0: return $urandom_range(120, 135);
      1: return $urandom_range(136, 400);
      default: return $urandom_range(0, 10);
    endcase
  endfunction

  task automatic add_pairs(ref byte_q_t q, input int count);
    int kl;
    int vl;
    repeat (count) begin
      kl = draw_len();
      vl = draw_len();
      put_length(q, kl, $urandom_range(0, 4) == 0);
      put_length(q, vl, $urandom_range(0, 4) == 0);
      repeat (kl + vl) q.push_back(rnd_byte());
    end
  endtask

  function automatic logic [15:0] draw_id();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int draw_pad();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
  endfunction

  // well-formed traffic; once STDIN has started, PARAMS records are skipped
  task automatic send_random_record(bit stdin_phase);
    byte_q_t    body;
    int         pick;
    logic [7:0] rtype;
    pick = $urandom_range(0, 9);
    if (pick < 6 && stdin_phase) begin
      rtype = TYPE_STDIN;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40))
        body.push_back(rnd_byte());
    end else if (pick < 8) begin
      rtype = TYPE_PARAMS;
      add_pairs(body, $urandom_range(0, 4));
    end else begin
      do rtype = rnd_byte(); while (rtype == TYPE_PARAMS || rtype == TYPE_STDIN);
      repeat ($urandom_range(0, 20)) body.push_back(rnd_byte());
    end
    send_record(rtype, draw_id(), body, draw_pad());
  endtask

  task automatic put_huge_length(ref byte_q_t q);
    logic [7:0] b0;
    b0 = 8'($urandom_range(128, 255));
    q.push_back(b0);
    // bits 16 and above must be set somewhere
    q.push_back((b0 == LONG_LEN_FLAG) ? 8'($urandom_range(1, 255)) : rnd_byte());
    q.push_back(rnd_byte());
    q.push_back(rnd_byte());
  endtask

  task automatic close_stream(stream_close_t how);
    byte_q_t body;
    int      kl;
    int      vl;
    bit      wide;
    if (how == END_OF_STREAM) begin
      send_record(TYPE_STDIN, draw_id(), body, draw_pad());
    end else begin
      add_pairs(body, $urandom_range(0, 2));
      wide = $urandom_range(0, 1);
      case (how)
        KEY_LEN_CUT: begin
          body.push_back(8'($urandom_range(128, 255)));
          repeat ($urandom_range(0, 2)) body.push_back(rnd_byte());
        end
        VALUE_LEN_MISSING: begin
          put_length(body, $urandom_range(0, 1) ? 65535 : $urandom_range(0, 300), wide);
        end
        VALUE_LEN_CUT: begin
          put_length(body, $urandom_range(0, 300), wide);
          body.push_back(8'($urandom_range(128, 255)));
          repeat ($urandom_range(0, 2)) body.push_back(rnd_byte());
        end
        PAIR_OVERRUN: begin
          if (wide) begin
            kl = 65535;
            vl = 0;
          end else begin
            kl = $urandom_range(0, 127);
            vl = $urandom_range(1, 127);
          end
          put_length(body, kl, wide);
          put_length(body, vl, wide);
          // short tail: the record ends before the pair does
          repeat ($urandom_range(0, (kl + vl - 1 > TAIL_MAX) ? TAIL_MAX : kl + vl - 1))
            body.push_back(rnd_byte());
        end
        KEY_LEN_HUGE: begin
          put_huge_length(body);
          repeat ($urandom_range(0, 5)) body.push_back(rnd_byte());
        end
        default: begin
          put_length(body, $urandom_range(0, 127), 1'b0);
          put_huge_length(body);
          repeat ($urandom_range(0, 5)) body.push_back(rnd_byte());
        end
      endcase
      send_record(TYPE_PARAMS, draw_id(), body, draw_pad());
    end
    // everything after the stream closes must be dropped
    repeat ($urandom_range(1, 20)) feed(rnd_byte());
  endtask

  function automatic dir_row_t row_in(logic [7:0] b);
    dir_row_t row;
    row.b       = b;
    row.has_res = 1'b0;
    row.res     = '0;
    return row;
  endfunction

  function automatic dir_row_t row_out(logic [7:0] b, logic [2:0] kind, logic [7:0] data,
                                       logic [15:0] kl, logic [15:0] vl, logic last);
    dir_row_t row;
    row.b                = b;
    row.has_res          = 1'b1;
    row.res.kind         = kind;
    row.res.data         = data;
    row.res.key_length   = kl;
    row.res.value_length = vl;
    row.res.request_id   = DIR_ID;
    row.res.last         = last;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    int   stall;
    res_t want;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (result.valid !== 1'b1) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data %02h", result.kind, result.data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(result.kind));
        check_field("data", 16'(want.data), 16'(result.data));
        check_field("key_length", want.key_length, result.key_length);
        check_field("value_length", want.value_length, result.value_length);
        check_field("request_id", want.request_id, result.request_id);
        check_field("last", 16'(want.last), 16'(result.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    stream_close_t how;
    int            stdin_from;
    int            settle;
    rst            <= 1'b1;
    stream.valid   <= 1'b0;
    stream.in_byte <= 8'h00;

    // PARAMS record with a short key length, a 4-byte value length and a
    // trailing empty pair, one padding byte, then an all-zero empty record
    dir_tab = '{
      row_in(8'hFF), row_in(TYPE_PARAMS), row_in(8'hFF), row_in(8'hFF),
      row_in(8'h00), row_in(8'h0A), row_in(8'h01), row_in(8'hFF),
      row_in(8'h01),
      row_in(8'h80), row_in(8'h00), row_in(8'h00),
      row_out(8'h02, KIND_PAIR, 8'h00, 16'd1, 16'd2, 1'b0),
      row_out(8'hFF, KIND_KEY, 8'hFF, 16'd0, 16'd0, 1'b1),
      row_out(8'h00, KIND_VALUE, 8'h00, 16'd0, 16'd0, 1'b0),
      row_out(8'h7F, KIND_VALUE, 8'h7F, 16'd0, 16'd0, 1'b1),
      row_in(8'h00),
      row_out(8'h00, KIND_PAIR, 8'h00, 16'd0, 16'd0, 1'b0),
      row_in(8'hAA),
      row_in(8'h00), row_in(8'h00), row_in(8'h00), row_in(8'h00),
      row_in(8'h00), row_in(8'h00), row_in(8'h00), row_in(8'h00)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    clear_parser();

    for (int i = 0; i < DIR_ROWS; i++) begin
      push_byte(dir_tab[i].b, dir_tab[i].has_res, dir_tab[i].res);
    end

    // errors only happen before STDIN, so half the runs end on an error
    how = $urandom_range(0, 1) ? END_OF_STREAM : stream_close_t'($urandom_range(1, 6));
    stdin_from = (how == END_OF_STREAM && $urandom_range(0, 7) != 0) ? STDIN_START : ITEMS;
    while (bytes_sent < ITEMS) begin
      send_random_record(bytes_sent >= stdin_from);
    end
    close_stream(how);
    stream.valid <= 1'b0;

    settle = 0;
    while (pending_results.size() != 0 && settle < SETTLE_LIMIT) begin
      @(posedge clk);
      settle++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: fastcgi_record_deframer.f
rtl/fcgi_pkg.sv
rtl/fcgi_in_if.sv
rtl/fcgi_out_if.sv
rtl/fcgi_parser.sv
rtl/fcgi_out_reg.sv
rtl/fastcgi_record_deframer.sv
tb/fastcgi_record_deframer_tb.sv
